>>> rtl/ffha_pkg.sv
// shared constants, control word and status types, microcode rom
// no dependencies
package ffha_pkg;

    localparam int HEAP_WORDS = 1024;
    localparam int WORD_BYTES = 4;
    localparam int ADDR_W     = $clog2(HEAP_WORDS);
    localparam int SIZE_W     = ADDR_W + 1;
    localparam int HDR_W      = SIZE_W + 1;
    localparam int LEN_W      = 13;
    localparam int REL_W      = 11;
    localparam int PAY_W      = 11;
    localparam int NEED_W     = 12;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 16;
    localparam int UPC_W      = 4;

    localparam logic [HDR_W-1:0] HDR_RESET = {1'b0, SIZE_W'(HEAP_WORDS)};

    typedef logic [UPC_W-1:0] t_upc;

    // branch conditions
    localparam logic [3:0] C_NEVER    = 4'd0;
    localparam logic [3:0] C_ALWAYS   = 4'd1;
    localparam logic [3:0] C_NO_IN    = 4'd2;
    localparam logic [3:0] C_IS_FREE  = 4'd3;
    localparam logic [3:0] C_NEED_BIG = 4'd4;
    localparam logic [3:0] C_POS_END  = 4'd5;
    localparam logic [3:0] C_SZ_ZERO  = 4'd6;
    localparam logic [3:0] C_NOT_FIT  = 4'd7;
    localparam logic [3:0] C_NO_SPLIT = 4'd8;
    localparam logic [3:0] C_REL_BAD  = 4'd9;
    localparam logic [3:0] C_OUT_FULL = 4'd10;

    // result selection
    localparam logic [1:0] R_NONE  = 2'd0;
    localparam logic [1:0] R_ALLOC = 2'd1;
    localparam logic [1:0] R_FREE  = 2'd2;
    localparam logic [1:0] R_FAIL  = 2'd3;

    // program steps
    localparam t_upc S_IDLE     = 4'd0;
    localparam t_upc S_DISPATCH = 4'd1;
    localparam t_upc S_CHECK    = 4'd2;
    localparam t_upc S_READ     = 4'd3;
    localparam t_upc S_HDR      = 4'd4;
    localparam t_upc S_WALK     = 4'd5;
    localparam t_upc S_PLACE    = 4'd6;
    localparam t_upc S_SPLIT    = 4'd7;
    localparam t_upc S_FREE_RD  = 4'd8;
    localparam t_upc S_FREE_WR  = 4'd9;
    localparam t_upc S_FAIL     = 4'd10;
    localparam t_upc S_DONE     = 4'd11;

    typedef struct packed {
        logic       in_rdy;
        logic       clr_walk;
        logic       rd_pos;
        logic       rd_rel;
        logic       ld_hdr;
        logic       walk;
        logic       wr_alloc;
        logic       wr_split;
        logic       wr_free;
        logic [1:0] res_sel;
        logic       push;
        logic       endp;
        logic [3:0] cond;
        t_upc       target;
    } t_ctrl;

    typedef struct packed {
        logic no_in;
        logic is_free;
        logic need_big;
        logic pos_end;
        logic sz_zero;
        logic not_fit;
        logic no_split;
        logic rel_bad;
        logic out_full;
    } t_stat;

    function automatic t_ctrl ucode_rom(input t_upc upc);
        t_ctrl c;
        c = '0;
        case (upc)
            S_IDLE: begin
                c.in_rdy = 1'b1;
                c.cond   = C_NO_IN;
                c.target = S_IDLE;
            end
            S_DISPATCH: begin
                c.clr_walk = 1'b1;
                c.cond     = C_IS_FREE;
                c.target   = S_FREE_RD;
            end
            S_CHECK: begin
                c.cond   = C_NEED_BIG;
                c.target = S_FAIL;
            end
            S_READ: begin
                c.rd_pos = 1'b1;
                c.cond   = C_POS_END;
                c.target = S_FAIL;
            end
            S_HDR: begin
                c.ld_hdr = 1'b1;
                c.cond   = C_SZ_ZERO;
                c.target = S_FAIL;
            end
            S_WALK: begin
                c.walk   = 1'b1;
                c.cond   = C_NOT_FIT;
                c.target = S_READ;
            end
            S_PLACE: begin
                c.wr_alloc = 1'b1;
                c.res_sel  = R_ALLOC;
                c.cond     = C_NO_SPLIT;
                c.target   = S_DONE;
            end
            S_SPLIT: begin
                c.wr_split = 1'b1;
                c.cond     = C_ALWAYS;
                c.target   = S_DONE;
            end
            S_FREE_RD: begin
                c.rd_rel = 1'b1;
                c.cond   = C_REL_BAD;
                c.target = S_FAIL;
            end
            S_FREE_WR: begin
                c.wr_free = 1'b1;
                c.res_sel = R_FREE;
                c.cond    = C_ALWAYS;
                c.target  = S_DONE;
            end
            S_FAIL: begin
                c.res_sel = R_FAIL;
                c.cond    = C_NEVER;
            end
            S_DONE: begin
                c.push   = 1'b1;
                c.endp   = 1'b1;
                c.cond   = C_OUT_FULL;
                c.target = S_DONE;
            end
            default: begin
                c.endp = 1'b1;
                c.cond = C_NEVER;
            end
        endcase
        return c;
    endfunction

endpackage

>>> rtl/ffha_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ffha_seq.sv
// microcode sequencer: step counter, control rom lookup, conditional branch
// depends on ffha_pkg
module ffha_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ffha_pkg::t_stat i_stat,
    output ffha_pkg::t_ctrl o_ctrl
);

    import ffha_pkg::*;

    t_upc  r_upc;
    t_upc  n_upc;
    t_ctrl ctrl;
    logic  taken;

    assign ctrl = ucode_rom(r_upc);

    always_comb begin
        case (ctrl.cond)
            C_NEVER:    taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_NO_IN:    taken = i_stat.no_in;
            C_IS_FREE:  taken = i_stat.is_free;
            C_NEED_BIG: taken = i_stat.need_big;
            C_POS_END:  taken = i_stat.pos_end;
            C_SZ_ZERO:  taken = i_stat.sz_zero;
            C_NOT_FIT:  taken = i_stat.not_fit;
            C_NO_SPLIT: taken = i_stat.no_split;
            C_REL_BAD:  taken = i_stat.rel_bad;
            C_OUT_FULL: taken = i_stat.out_full;
            default:    taken = 1'b0;
        endcase
        if (taken) begin
            n_upc = ctrl.target;
        end else if (ctrl.endp) begin
            n_upc = S_IDLE;
        end else begin
            n_upc = r_upc + t_upc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl = ctrl;

endmodule

>>> rtl/ffha_dp.sv
// datapath: request registers, walk registers, header store, result register
// depends on ffha_pkg and ffha_ram
module ffha_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ffha_pkg::t_ctrl                 i_ctrl,
    output ffha_pkg::t_stat                 o_stat,
    input  logic                            i_in_valid,
    input  logic                            i_in_op,
    input  logic [ffha_pkg::LEN_W-1:0]      i_in_len,
    input  logic [ffha_pkg::REL_W-1:0]      i_in_rel,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_out_ok,
    output logic [ffha_pkg::PAY_W-1:0]      o_out_pay
);

    import ffha_pkg::*;

    logic                r_op;
    logic [NEED_W-1:0]   r_need;
    logic [REL_W-1:0]    r_rel;
    logic [SIZE_W-1:0]   r_pos;
    logic [SIZE_W-1:0]   r_run;
    logic [ADDR_W-1:0]   r_start;
    logic [HDR_W-1:0]    r_hdr;
    logic                r_rd_zero;
    logic                r_h0_fresh;
    logic                r_res_ok;
    logic [PAY_W-1:0]    r_res_pay;
    logic                r_out_vld;
    logic                r_out_ok;
    logic [PAY_W-1:0]    r_out_pay;

    logic [LEN_W:0]      len_round;
    logic [NEED_W-1:0]   n_need;
    logic [HDR_W-1:0]    ram_rdata;
    logic [HDR_W-1:0]    hdr_data;
    logic [SIZE_W-1:0]   room;
    logic [SIZE_W-1:0]   hdr_size;
    logic [SIZE_W-1:0]   size_cut;
    logic [NEED_W-1:0]   run_sum;
    logic [REL_W-1:0]    rel_dec;
    logic [ADDR_W-1:0]   rel_addr;
    logic                accept;
    logic                out_full;
    logic                re;
    logic [ADDR_W-1:0]   raddr;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [HDR_W-1:0]    wdata;

    assign accept    = i_in_valid && i_ctrl.in_rdy;
    assign len_round = {1'b0, i_in_len} + (LEN_W + 1)'(WORD_BYTES - 1);
    assign n_need    = len_round[LEN_W:2] + NEED_W'(1);

    assign hdr_data  = (r_rd_zero && r_h0_fresh) ? HDR_RESET : ram_rdata;
    assign hdr_size  = r_hdr[SIZE_W-1:0];
    assign room      = SIZE_W'(HEAP_WORDS) - r_pos;
    assign size_cut  = (hdr_size > room) ? room : hdr_size;
    assign run_sum   = {1'b0, r_run} + {1'b0, size_cut};
    assign rel_dec   = r_rel - REL_W'(1);
    assign rel_addr  = rel_dec[ADDR_W-1:0];
    assign out_full  = r_out_vld && !i_out_ready;

    assign o_stat.no_in    = !i_in_valid;
    assign o_stat.is_free  = r_op;
    assign o_stat.need_big = r_need > NEED_W'(HEAP_WORDS);
    assign o_stat.pos_end  = r_pos >= SIZE_W'(HEAP_WORDS);
    assign o_stat.sz_zero  = hdr_data[SIZE_W-1:0] == '0;
    assign o_stat.not_fit  = r_hdr[HDR_W-1] || (run_sum < r_need);
    assign o_stat.no_split = {1'b0, r_run} == r_need;
    assign o_stat.rel_bad  = (r_rel == '0) || (r_rel > REL_W'(HEAP_WORDS));
    assign o_stat.out_full = out_full;

    assign re    = i_ctrl.rd_pos || i_ctrl.rd_rel;
    assign raddr = i_ctrl.rd_pos ? r_pos[ADDR_W-1:0] : rel_addr;

    always_comb begin
        we    = 1'b0;
        waddr = r_start;
        wdata = {1'b1, r_need[SIZE_W-1:0]};
        if (i_ctrl.wr_alloc) begin
            we = 1'b1;
        end else if (i_ctrl.wr_split) begin
            we    = 1'b1;
            waddr = r_start + r_need[ADDR_W-1:0];
            wdata = {1'b0, r_run - r_need[SIZE_W-1:0]};
        end else if (i_ctrl.wr_free) begin
            we    = 1'b1;
            waddr = rel_addr;
            wdata = {1'b0, hdr_data[SIZE_W-1:0]};
        end
    end

    ffha_ram #(
        .WIDTH (HDR_W),
        .DEPTH (HEAP_WORDS)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_in_op;
            r_need <= n_need;
            r_rel  <= i_in_rel;
        end
        if (re) begin
            r_rd_zero <= raddr == '0;
        end
        if (i_ctrl.ld_hdr) begin
            r_hdr <= hdr_data;
        end
        if (i_ctrl.clr_walk) begin
            r_pos   <= '0;
            r_run   <= '0;
            r_start <= '0;
        end else if (i_ctrl.walk) begin
            if (r_run == '0) begin
                r_start <= r_pos[ADDR_W-1:0];
            end
            if (r_hdr[HDR_W-1]) begin
                r_run <= '0;
            end else begin
                r_run <= run_sum[SIZE_W-1:0];
            end
            r_pos <= r_pos + size_cut;
        end
        case (i_ctrl.res_sel)
            R_ALLOC: begin
                r_res_ok  <= 1'b1;
                r_res_pay <= {1'b0, r_start} + PAY_W'(1);
            end
            R_FREE: begin
                r_res_ok  <= 1'b1;
                r_res_pay <= '0;
            end
            R_FAIL: begin
                r_res_ok  <= 1'b0;
                r_res_pay <= '0;
            end
            default: begin
            end
        endcase
        if (i_ctrl.push && !out_full) begin
            r_out_ok  <= r_res_ok;
            r_out_pay <= r_res_pay;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_h0_fresh <= 1'b1;
        end else begin
            if (i_ctrl.push && !out_full) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (we && (waddr == '0)) begin
                r_h0_fresh <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_ok    = r_out_ok;
    assign o_out_pay   = r_out_pay;

endmodule

>>> rtl/first_fit_heap_allocator_unit.sv
// first-fit heap allocator top level: microcode sequencer plus datapath
// depends on ffha_pkg, ffha_seq, ffha_dp (which holds ffha_ram)
//
//  channel   direction  tdata                                    tuser
//  s_axis    in         [12:0] length_bytes, [23:13] release_word  [0] op
//  m_axis    out        [10:0] payload_word, [15:11] zero          [0] ok
//
// one transaction at a time
// an allocate walks the headers one by one, set by
// the one read port of the header ram (read, capture, update per header)
// the next request is taken while a result waits in the output register
// reset is synchronous; no clearing pass, header word 0 reads as one free block
// until it is first written
module first_fit_heap_allocator_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [ffha_pkg::S_DATA_W-1:0]        s_axis_tdata,  // length_bytes, release_word
    input  logic [0:0]                           s_axis_tuser,  // op
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [ffha_pkg::M_DATA_W-1:0]        m_axis_tdata,  // payload_word, zero fill
    output logic [0:0]                           m_axis_tuser   // ok
);

    import ffha_pkg::*;

    t_ctrl            ctrl;
    t_stat            stat;
    logic             out_ok;
    logic [PAY_W-1:0] out_pay;

    ffha_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    ffha_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_in_valid  (s_axis_tvalid),
        .i_in_op     (s_axis_tuser[0]),
        .i_in_len    (s_axis_tdata[LEN_W-1:0]),
        .i_in_rel    (s_axis_tdata[LEN_W+REL_W-1:LEN_W]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_ok    (out_ok),
        .o_out_pay   (out_pay)
    );

    assign s_axis_tready = ctrl.in_rdy && i_rst_n;
    assign m_axis_tdata  = {(M_DATA_W - PAY_W)'(0), out_pay};
    assign m_axis_tuser  = out_ok;

endmodule

>>> test/first_fit_heap_allocator_unit_chk.sv
`timescale 1ns / 1ps
// request codes and the result checker for the first-fit heap allocator
// depends on ffha_pkg; watches both stream channels of the unit, no rtl internals
package ffha_tb_pkg;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

endpackage

module first_fit_heap_allocator_unit_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [ffha_pkg::S_DATA_W-1:0]  i_s_tdata,   // length_bytes, release_word
    input  logic [0:0]                     i_s_tuser,   // op
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [ffha_pkg::M_DATA_W-1:0]  i_m_tdata,   // payload_word, zero fill
    input  logic [0:0]                     i_m_tuser,   // ok
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);

    import ffha_pkg::*;
    import ffha_tb_pkg::*;

    typedef struct packed {
        logic             ok;
        logic [PAY_W-1:0] payload;
    } t_outcome;

    logic [HDR_W-1:0] heap_hdr [HEAP_WORDS];
    t_outcome         outcome_q [$];

    // first-fit walk with lazy merging of adjacent free blocks
    function automatic t_outcome heap_request(input t_op op, input logic [LEN_W-1:0] len,
                                              input logic [REL_W-1:0] rel);
        t_outcome         res;
        int               need_w;
        int               pos;
        int               run;
        int               start;
        int               sz;
        int               rel_i;
        logic [HDR_W-1:0] h;
        res    = '0;
        rel_i  = int'(rel);
        need_w = (int'(len) + WORD_BYTES - 1) / WORD_BYTES + 1;
        pos    = 0;
        run    = 0;
        start  = 0;
        if (op == OP_FREE) begin
            if (rel_i >= 1 && rel_i - 1 < HEAP_WORDS) begin
                heap_hdr[rel_i-1][HDR_W-1] = 1'b0;
                res.ok = 1'b1;
            end
            return res;
        end
        if (need_w > HEAP_WORDS)
            return res;
        while (pos < HEAP_WORDS) begin
            h  = heap_hdr[pos];
            sz = int'(h[SIZE_W-1:0]);
            if (sz == 0)
                return res;
            if (sz > HEAP_WORDS - pos)
                sz = HEAP_WORDS - pos;
            if (run == 0)
                start = pos;
            if (h[HDR_W-1]) begin
                run = 0;
            end else begin
                run += sz;
                if (run >= need_w) begin
                    heap_hdr[start] = {1'b1, SIZE_W'(need_w)};
                    if (run > need_w && start + need_w < HEAP_WORDS)
                        heap_hdr[start+need_w] = {1'b0, SIZE_W'(run - need_w)};
                    res.ok      = 1'b1;
                    res.payload = PAY_W'(start + 1);
                    return res;
                end
            end
            pos += sz;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome exp_res;
        if (!i_rst_n) begin
            for (int i = 0; i < HEAP_WORDS; i++)
                heap_hdr[i] = '0;
            heap_hdr[0] = {1'b0, SIZE_W'(HEAP_WORDS)};
            outcome_q.delete();
        end else begin
            // result first, so a result never meets the request of the same edge
            if (i_m_tvalid && i_m_tready) begin
                o_checked++;
                if (outcome_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t unexpected result: expected none actual ok=%0d payload=%0d",
                             $time, i_m_tuser[0], i_m_tdata[PAY_W-1:0]);
                end else begin
                    exp_res = outcome_q.pop_front();
                    if (i_m_tuser[0] !== exp_res.ok) begin
                        o_fail_count++;
                        $display("%0t ok mismatch: expected %0d actual %0d",
                                 $time, exp_res.ok, i_m_tuser[0]);
                    end
                    if (i_m_tdata[PAY_W-1:0] !== exp_res.payload) begin
                        o_fail_count++;
                        $display("%0t payload_word mismatch: expected %0d actual %0d",
                                 $time, exp_res.payload, i_m_tdata[PAY_W-1:0]);
                    end
                    if (i_m_tdata[M_DATA_W-1:PAY_W] !== '0) begin
                        o_fail_count++;
                        $display("%0t tdata fill mismatch: expected 0 actual %h",
                                 $time, i_m_tdata[M_DATA_W-1:PAY_W]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                outcome_q.push_back(heap_request(t_op'(i_s_tuser[0]), i_s_tdata[LEN_W-1:0],
                                                 i_s_tdata[LEN_W+REL_W-1:LEN_W]));
        end
        o_pending = outcome_q.size();
    end

endmodule

>>> test/first_fit_heap_allocator_unit_tb.sv
`timescale 1ns / 1ps
// testbench top for the first-fit heap allocator: clock, reset, request stimulus, verdict
// depends on ffha_pkg, ffha_tb_pkg, first_fit_heap_allocator_unit and first_fit_heap_allocator_unit_chk
module first_fit_heap_allocator_unit_tb;

    import ffha_pkg::*;
    import ffha_tb_pkg::*;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;   // length_bytes, release_word
    logic [0:0]            s_axis_tuser  = '0;   // op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;         // payload_word, zero fill
    logic [0:0]            m_axis_tuser;         // ok

    int fail_count;
    int pending;
    int checked;
    int n_alloc   = 0;
    int n_free    = 0;
    bit hold_req  = 1'b0;
    bit no_idle   = 1'b0;
    int live_q [$];
    int seen_q [$];

    always #2 i_clk = ~i_clk;

    first_fit_heap_allocator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    first_fit_heap_allocator_unit_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // result side: random stalls, a quiet stretch, and a long hold-off on request
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (no_idle) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 13);
            end
        end
    end

    // granted payload words; their headers are known to be written
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready && m_axis_tuser[0]
                && m_axis_tdata[PAY_W-1:0] != 0) begin
            live_q.push_back(int'(m_axis_tdata[PAY_W-1:0]));
            seen_q.push_back(int'(m_axis_tdata[PAY_W-1:0]));
        end
    end

    task automatic send_request(input t_op op, input int len, input int rel);
        while (!no_idle && $urandom_range(99) < 13) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {REL_W'(rel), LEN_W'(len)};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (op == OP_ALLOC)
            n_alloc++;
        else
            n_free++;
    endtask

    task automatic alloc_block(input int len);
        send_request(OP_ALLOC, len, $urandom_range(2047));
    endtask

    task automatic free_block(input int rel);
        int hits [$];
        hits = live_q.find_first_index(x) with (x == rel);
        if (hits.size() > 0)
            live_q.delete(hits[0]);
        send_request(OP_FREE, $urandom_range(8191), rel);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        #60_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int r;
        int idx;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: sizes, rounding, merges, exact fit, full heap, range checks
        alloc_block(0);
        alloc_block(1);
        alloc_block(4);
        alloc_block(5);
        alloc_block(4092);
        alloc_block(4096);
        alloc_block(8191);
        free_block(0);
        free_block(1025);
        free_block(2047);
        free_block(2);
        free_block(4);
        alloc_block(8);
        free_block(4);
        free_block(1);
        alloc_block(4056);
        alloc_block(0);
        alloc_block(0);
        alloc_block(0);
        alloc_block(0);
        free_block(1024);
        alloc_block(4);
        free_block(9);
        alloc_block(4060);
        wait_drained();
        free_block(9);

        for (int i = 0; i < 1000; i++) begin
            if (i == 300)
                hold_req = 1'b1;
            if (i == 400)
                no_idle = 1'b1;
            if (i == 550)
                no_idle = 1'b0;
            if (i == 700)
                wait_drained();
            r = $urandom_range(99);
            if (live_q.size() > 0 && (r < 40 || live_q.size() > 40)) begin
                idx = $urandom_range(live_q.size() - 1);
                free_block(live_q[idx]);
            end else if (r < 46 && seen_q.size() > 0) begin
                free_block(seen_q[$urandom_range(seen_q.size() - 1)]);
            end else if (r < 50) begin
                free_block(($urandom_range(3) == 0) ? 0 : $urandom_range(2047, 1025));
            end else if (r < 60) begin
                alloc_block($urandom_range(4096));
            end else if (r < 63) begin
                alloc_block($urandom_range(8191, 4097));
            end else begin
                alloc_block($urandom_range(128));
            end
        end
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("covered %0d allocate and %0d free requests, %0d results compared",
                 n_alloc, n_free, checked);
        $display("incl. exact fits, merged free runs, a full heap, bad frees, output stall");
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
